// ===== rtl/gibs_pkg.sv =====
// Shared types, constants and helpers for the greedy IoU box suppression block.
// No dependencies; all other files refer to it by scoped names.
package gibs_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int IDX_W      = $clog2(MAX_BOXES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_W    = 16;
  localparam int THR_W      = 17;
  localparam int SPAN_W     = COORD_W + 2;
  localparam int AREA_W     = 2 * SPAN_W;
  localparam int PROD_W     = AREA_W + SPAN_W;
  localparam int CFG_ADDR_W = 3;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IOU_THRESHOLD = 3'd0
  } cfg_reg_t;

  // One stored box: corners and score.
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] score;
  } box_t;

  // hi - lo as a signed value
  function automatic logic signed [SPAN_W-1:0] span(input logic [COORD_W-1:0] lo,
                                                     input logic [COORD_W-1:0] hi);
    return $signed({2'b00, hi}) - $signed({2'b00, lo});
  endfunction

  function automatic logic [COORD_W-1:0] umax(input logic [COORD_W-1:0] a,
                                              input logic [COORD_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [COORD_W-1:0] umin(input logic [COORD_W-1:0] a,
                                              input logic [COORD_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== rtl/gibs_box_if.sv =====
// Input channel: one box per transaction, valid/ready handshake.
// Depends on gibs_pkg for widths.
interface gibs_box_if;
  logic                           valid;
  logic                           ready;
  logic [gibs_pkg::COORD_W-1:0]   box_left;
  logic [gibs_pkg::COORD_W-1:0]   box_top;
  logic [gibs_pkg::COORD_W-1:0]   box_right;
  logic [gibs_pkg::COORD_W-1:0]   box_bottom;
  logic [gibs_pkg::COORD_W-1:0]   box_score;
  logic                           set_last;

  modport source (output valid, box_left, box_top, box_right, box_bottom, box_score,
                  set_last, input ready);
  modport sink   (input valid, box_left, box_top, box_right, box_bottom, box_score,
                  set_last, output ready);
endinterface

// ===== rtl/gibs_kept_if.sv =====
// Output channel: one kept box per transaction, valid/ready handshake.
// Depends on gibs_pkg for widths.
interface gibs_kept_if;
  logic                           valid;
  logic                           ready;
  logic [gibs_pkg::COORD_W-1:0]   kept_left;
  logic [gibs_pkg::COORD_W-1:0]   kept_top;
  logic [gibs_pkg::COORD_W-1:0]   kept_right;
  logic [gibs_pkg::COORD_W-1:0]   kept_bottom;
  logic [gibs_pkg::COORD_W-1:0]   kept_score;
  logic                           result_last;
  logic                           overflowed;

  modport source (output valid, kept_left, kept_top, kept_right, kept_bottom, kept_score,
                  result_last, overflowed, input ready);
  modport sink   (input valid, kept_left, kept_top, kept_right, kept_bottom, kept_score,
                  result_last, overflowed, output ready);
endinterface

// ===== rtl/gibs_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on gibs_pkg for operand widths.
module gibs_mul (
  input  logic                                 clk,
  input  logic signed [gibs_pkg::AREA_W-1:0]   a,
  input  logic signed [gibs_pkg::SPAN_W-1:0]   b,
  output logic signed [gibs_pkg::PROD_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= gibs_pkg::PROD_W'(a) * gibs_pkg::PROD_W'(b);
  end

endmodule

// ===== rtl/greedy_iou_box_suppression.sv =====
// Top level of greedy IoU non-maximum suppression: sorted box store, sequencer,
// configuration port. Depends on gibs_pkg, gibs_box_if, gibs_kept_if, gibs_mul.
//
// Channel   | Dir | Transaction
// ----------+-----+----------------------------------------------
// box_in    | in  | one box (corners, score, set_last)
// kept_out  | out | one kept box (corners, score, last, overflow)
// APB       | in  | write/read of iou_threshold at byte address 0
//
// Loading: every stored entry of lower score moves down one slot (insertion into
// the score-sorted memory, one read port), then the new box is written into the
// free slot; the next box is accepted only after that.
// Suppression: each kept box is tested against every later box, all on one
// shared multiplier; each kept result then waits for the output handshake.
// box_in.ready is high only while idle. Reset (rst, synchronous) empties the set
// and restores the threshold; memory contents are left as they are.
module greedy_iou_box_suppression (
  input  logic                               clk,
  input  logic                               rst,
  gibs_box_if.sink                           box_in,
  gibs_kept_if.source                        kept_out,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gibs_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CHK, S_O_RD, S_O_LD, S_O_AREA,
    S_P_RD, S_P_LD, S_P_INT, S_P_AB, S_P_TH, S_P_CMP, S_EMIT
  } state_t;

  state_t                             state;
  logic [gibs_pkg::THR_W-1:0]         thr;
  logic [gibs_pkg::CNT_W-1:0]         count;
  logic                               ovf;
  logic [gibs_pkg::MAX_BOXES-1:0]     flags;
  gibs_pkg::box_t                     newbox;
  logic                               new_last;
  logic [gibs_pkg::CNT_W-1:0]         k;      // insertion slot
  logic [gibs_pkg::CNT_W-1:0]         i;      // current kept box
  logic [gibs_pkg::CNT_W-1:0]         j;      // box under test
  logic [gibs_pkg::CNT_W-1:0]         next_i; // first survivor after i
  logic                               found;
  gibs_pkg::box_t                     box_a;
  gibs_pkg::box_t                     box_b;
  logic signed [gibs_pkg::AREA_W-1:0] area_a;
  logic signed [gibs_pkg::AREA_W-1:0] inter;
  logic signed [gibs_pkg::AREA_W-1:0] uni;

  // sorted store, one read and one write port, registered read
  gibs_pkg::box_t                     mem [gibs_pkg::MAX_BOXES];
  gibs_pkg::box_t                     rdata;
  logic [gibs_pkg::IDX_W-1:0]         raddr;
  logic                               we;
  logic [gibs_pkg::IDX_W-1:0]         waddr;
  gibs_pkg::box_t                     wdata;

  logic signed [gibs_pkg::AREA_W-1:0] mul_a;
  logic signed [gibs_pkg::SPAN_W-1:0] mul_b;
  logic signed [gibs_pkg::PROD_W-1:0] mres;

  logic signed [gibs_pkg::SPAN_W-1:0] iw, ih;
  logic                               hit;
  logic                               flag_j;
  logic                               cfg_wr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  gibs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mres));

  // intersection spans of box_a against the box just read, clamped at zero
  always_comb begin
    iw = gibs_pkg::span(gibs_pkg::umax(box_a.left, rdata.left),
                        gibs_pkg::umin(box_a.right, rdata.right));
    ih = gibs_pkg::span(gibs_pkg::umax(box_a.top, rdata.top),
                        gibs_pkg::umin(box_a.bottom, rdata.bottom));
    if (iw < 0) iw = '0;
    if (ih < 0) ih = '0;
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_O_LD: begin
        mul_a = gibs_pkg::AREA_W'(gibs_pkg::span(rdata.left, rdata.right));
        mul_b = gibs_pkg::span(rdata.top, rdata.bottom);
      end
      S_P_LD: begin
        mul_a = gibs_pkg::AREA_W'(iw);
        mul_b = ih;
      end
      S_P_INT: begin
        mul_a = gibs_pkg::AREA_W'(gibs_pkg::span(box_b.left, box_b.right));
        mul_b = gibs_pkg::span(box_b.top, box_b.bottom);
      end
      S_P_TH: begin
        mul_a = uni;
        mul_b = $signed({1'b0, thr});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // memory address and write control
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = k[gibs_pkg::IDX_W-1:0];
    wdata = newbox;
    unique case (state)
      S_INS_RD: begin
        if (k == '0) begin
          we = 1'b1;
        end else begin
          raddr = gibs_pkg::IDX_W'(k - 1'b1);
        end
      end
      S_INS_CHK: begin
        we = 1'b1;
        if (rdata.score < newbox.score) begin
          wdata = rdata;
        end
      end
      S_O_RD:  raddr = i[gibs_pkg::IDX_W-1:0];
      S_P_RD:  raddr = j[gibs_pkg::IDX_W-1:0];
      default: raddr = '0;
    endcase
  end

  // inter*65536 > thr*union, never when the union is not positive
  assign hit    = (uni > 0) &&
                  ($signed({2'b00, inter, 16'b0}) > mres);
  assign flag_j = flags[j[gibs_pkg::IDX_W-1:0]] | hit;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = 32'(thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      thr   <= gibs_pkg::THR_RESET;
      count <= '0;
      ovf   <= 1'b0;
      flags <= '0;
      found <= 1'b0;
    end else begin
      if (cfg_wr && paddr == gibs_pkg::REG_IOU_THRESHOLD) begin
        thr <= pwdata[gibs_pkg::THR_W-1:0];
      end
      unique case (state)
        S_IDLE: begin
          if (box_in.valid) begin
            newbox   <= '{box_in.box_left, box_in.box_top, box_in.box_right,
                          box_in.box_bottom, box_in.box_score};
            new_last <= box_in.set_last;
            k        <= count;
            if (count == gibs_pkg::CNT_W'(gibs_pkg::MAX_BOXES)) begin
              // store full: drop the box
              ovf <= 1'b1;
              if (box_in.set_last) begin
                i     <= '0;
                state <= S_O_RD;
              end
            end else begin
              state <= S_INS_RD;
            end
          end
        end
        S_INS_RD: begin
          if (k == '0) begin
            count <= count + 1'b1;
            if (new_last) begin
              i     <= '0;
              state <= S_O_RD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_INS_CHK;
          end
        end
        S_INS_CHK: begin
          if (rdata.score < newbox.score) begin
            k     <= k - 1'b1;
            state <= S_INS_RD;
          end else begin
            count <= count + 1'b1;
            if (new_last) begin
              i     <= '0;
              state <= S_O_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_O_RD: begin
          state <= S_O_LD;
        end
        S_O_LD: begin
          box_a <= rdata;
          state <= S_O_AREA;
        end
        S_O_AREA: begin
          area_a <= mres[gibs_pkg::AREA_W-1:0];
          j      <= i + 1'b1;
          found  <= 1'b0;
          if (i + 1'b1 == count) begin
            state <= S_EMIT;
          end else begin
            state <= S_P_RD;
          end
        end
        S_P_RD: begin
          state <= S_P_LD;
        end
        S_P_LD: begin
          box_b <= rdata;
          state <= S_P_INT;
        end
        S_P_INT: begin
          inter <= mres[gibs_pkg::AREA_W-1:0];
          state <= S_P_AB;
        end
        S_P_AB: begin
          uni   <= area_a + mres[gibs_pkg::AREA_W-1:0] - inter;
          state <= S_P_TH;
        end
        S_P_TH: begin
          state <= S_P_CMP;
        end
        S_P_CMP: begin
          flags[j[gibs_pkg::IDX_W-1:0]] <= flag_j;
          if (!flag_j && !found) begin
            found  <= 1'b1;
            next_i <= j;
          end
          j <= j + 1'b1;
          if (j + 1'b1 == count) begin
            state <= S_EMIT;
          end else begin
            state <= S_P_RD;
          end
        end
        S_EMIT: begin
          if (kept_out.ready) begin
            if (found) begin
              i     <= next_i;
              state <= S_O_RD;
            end else begin
              count <= '0;
              ovf   <= 1'b0;
              flags <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a set with no stored box (only possible if empty) produces nothing
  // count never zero when processing starts, since a full store has MAX_BOXES

  assign box_in.ready         = (state == S_IDLE);
  assign kept_out.valid       = (state == S_EMIT);
  assign kept_out.kept_left   = box_a.left;
  assign kept_out.kept_top    = box_a.top;
  assign kept_out.kept_right  = box_a.right;
  assign kept_out.kept_bottom = box_a.bottom;
  assign kept_out.kept_score  = box_a.score;
  assign kept_out.result_last = !found;
  assign kept_out.overflowed  = ovf;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= gibs_pkg::CNT_W'(gibs_pkg::MAX_BOXES))
    else $error("box count beyond capacity");

  a_emit_in_set: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> i < count)
    else $error("kept box index outside the set");

  a_idle_flags_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> flags == '0)
    else $error("suppression flags left set between sets");

  a_next_after_i: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && found) |-> next_i > i)
    else $error("next kept box not after current one");
`endif

endmodule
